// File: sv/met_pkg.sv
// Shared types and constants for the Mandelbrot escape-time core.
package met_pkg;

  localparam int FRAC_BITS  = 28;
  localparam int COORD_W    = 32;
  localparam int STEP_W     = 29;
  localparam int POS_W      = 10;
  localparam int CNT_W      = 8;
  localparam int Z_W        = 36;
  localparam int CIDX_W     = 3;
  localparam int QDEPTH     = 2;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] REG_ORIGIN_REAL = 3'd0;
  localparam logic [CIDX_W-1:0] REG_ORIGIN_IMAG = 3'd1;
  localparam logic [CIDX_W-1:0] REG_STEP_REAL   = 3'd2;
  localparam logic [CIDX_W-1:0] REG_STEP_IMAG   = 3'd3;
  localparam logic [CIDX_W-1:0] REG_ITER_LIMIT  = 3'd4;

  // one classified pixel travelling from front to back
  typedef struct packed {
    logic signed [COORD_W-1:0] cr;
    logic signed [COORD_W-1:0] ci;
    logic [POS_W-1:0]          column;
    logic [POS_W-1:0]          row;
  } met_item_t;

endpackage

// File: sv/mandelbrot_escape_time_core.sv
// Top level of the Mandelbrot escape-time core.
// Usage:
//   Input queue: drive in_column/in_row and raise in_push; a pixel transfers
//   on a clock edge with in_push high and in_full low.
//   Result queue: while out_empty is low the oldest result (iteration count
//   and echoed position) sits on the out_ ports; it transfers on an edge with
//   out_pop high. Results come out in input order, one per pixel.
//   Config: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
//   always high. Unknown indexes are dropped. Write only while idle.
// Timing: the front end maps the pixel to c in the transfer cycle and parks
//   it in a two-entry queue. Each iteration of the engine takes one multiply
//   state (three 31x31 products) and one add and escape-test state. A pixel
//   taking N iterations passes a load in the idle state, N + 1 multiply/add
//   pairs (the last one tests the final z) and a write-back state; the last
//   pair stops after its multiply state when a component is already at or
//   beyond 4.0. The result register is loaded in the write-back state.
//   One pixel at a time is iterated; the engine takes the next pixel only
//   after the current one has been written back. The default limit is 32.
// Reset: synchronous, active low; queues empty, config to its default view.
// Stall: a held result blocks the engine in its write-back state; the input
//   queue keeps taking pixels until both entries are filled.
module mandelbrot_escape_time_core #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic [met_pkg::POS_W-1:0]         in_column,
  input  logic [met_pkg::POS_W-1:0]         in_row,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [met_pkg::CNT_W-1:0]         out_iteration_count,
  output logic [met_pkg::POS_W-1:0]         out_column_out,
  output logic [met_pkg::POS_W-1:0]         out_row_out,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [met_pkg::CIDX_W-1:0]        cfg_index,
  input  logic [met_pkg::COORD_W-1:0]       cfg_data
);
  import met_pkg::*;

  logic signed [COORD_W-1:0] origin_real_r, origin_imag_r;
  logic [STEP_W-1:0]         step_real_r, step_imag_r;
  logic [CNT_W-1:0]          limit_r;
  met_item_t                 front_item, q_item;
  logic                      q_valid, q_pop;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_real_r <= -32'sd563714458;
      origin_imag_r <= -32'sd322122547;
      step_real_r   <= STEP_W'(1132462);
      step_imag_r   <= STEP_W'(1342177);
      limit_r       <= CNT_W'(32);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ORIGIN_REAL: origin_real_r <= cfg_data;
        REG_ORIGIN_IMAG: origin_imag_r <= cfg_data;
        REG_STEP_REAL:   step_real_r   <= cfg_data[STEP_W-1:0];
        REG_STEP_IMAG:   step_imag_r   <= cfg_data[STEP_W-1:0];
        REG_ITER_LIMIT:  limit_r       <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  met_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_front (
    .in_column   (in_column),
    .in_row      (in_row),
    .origin_real (origin_real_r),
    .origin_imag (origin_imag_r),
    .step_real   (step_real_r),
    .step_imag   (step_imag_r),
    .item        (front_item)
  );

  met_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .push_item (front_item),
    .full      (in_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_item  (q_item)
  );

  met_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_valid),
    .q_item              (q_item),
    .q_pop               (q_pop),
    .iteration_limit     (limit_r),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_iteration_count (out_iteration_count),
    .out_column_out      (out_column_out),
    .out_row_out         (out_row_out)
  );

  // a shown result always counts at least one iteration
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_iteration_count != '0)
    else $error("result with zero iteration count");

  // a shown result never exceeds the limit (a zero limit acts as one)
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_iteration_count <= limit_r || out_iteration_count == 8'd1))
    else $error("iteration count beyond limit");

  // a pixel leaves the queue only when the queue holds one
  a_queue_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("engine took from an empty queue");

endmodule

// File: sv/met_front.sv
// Front end: clamps the pixel position and maps it to the point c.
module met_front #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 1024
) (
  input  logic [met_pkg::POS_W-1:0]           in_column,
  input  logic [met_pkg::POS_W-1:0]           in_row,
  input  logic signed [met_pkg::COORD_W-1:0]  origin_real,
  input  logic signed [met_pkg::COORD_W-1:0]  origin_imag,
  input  logic [met_pkg::STEP_W-1:0]          step_real,
  input  logic [met_pkg::STEP_W-1:0]          step_imag,
  output met_pkg::met_item_t                  item
);
  import met_pkg::*;

  localparam int CP_W = 13;
  localparam logic [CP_W-1:0] COL_LAST = CP_W'(MAX_COLUMNS - 1);
  localparam logic [CP_W-1:0] ROW_LAST = CP_W'(MAX_ROWS - 1);
  localparam int PR_W  = CP_W + STEP_W;
  localparam int SUM_W = PR_W + 2;

  // origin + pos * step, saturated to Q4.28
  function automatic logic signed [COORD_W-1:0] coord(
    input logic signed [COORD_W-1:0] org,
    input logic [CP_W-1:0]           pos,
    input logic [STEP_W-1:0]         step
  );
    logic [PR_W-1:0]         prod;
    logic signed [SUM_W-1:0] sum;
    prod = PR_W'(pos) * PR_W'(step);
    sum  = $signed({2'b00, prod}) + SUM_W'(org);
    if (sum > $signed(SUM_W'({1'b0, {(COORD_W-1){1'b1}}})))
      coord = {1'b0, {(COORD_W-1){1'b1}}};
    else if (sum < -$signed(SUM_W'({1'b1, {(COORD_W-1){1'b0}}})))
      coord = {1'b1, {(COORD_W-1){1'b0}}};
    else
      coord = sum[COORD_W-1:0];
  endfunction

  logic [CP_W-1:0] col_ext;
  logic [CP_W-1:0] row_ext;
  logic [CP_W-1:0] cpos;
  logic [CP_W-1:0] rpos;

  // clamp positions beyond the view
  always_comb begin
    col_ext = CP_W'(in_column);
    row_ext = CP_W'(in_row);
    cpos    = (col_ext > COL_LAST) ? COL_LAST : col_ext;
    rpos    = (row_ext > ROW_LAST) ? ROW_LAST : row_ext;
    item.cr     = coord(origin_real, cpos, step_real);
    item.ci     = coord(origin_imag, rpos, step_imag);
    item.column = in_column;
    item.row    = in_row;
  end

endmodule

// File: sv/met_queue.sv
// Two-entry queue between the front end and the iteration engine.
module met_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  met_pkg::met_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               valid,
  output met_pkg::met_item_t pop_item
);
  import met_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W_Q = $clog2(QDEPTH + 1);

  met_item_t            mem_r [QDEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W_Q-1:0]   cnt_r, cnt_nxt;
  logic                 do_push, do_pop;

  assign full     = (cnt_r == CNT_W_Q'(QDEPTH));
  assign valid    = (cnt_r != '0);
  assign pop_item = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W_Q'(do_push) - CNT_W_Q'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: sv/met_back.sv
// Iteration engine: runs z = z^2 + c and holds the result register.
module met_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  met_pkg::met_item_t          q_item,
  output logic                        q_pop,
  input  logic [met_pkg::CNT_W-1:0]   iteration_limit,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [met_pkg::CNT_W-1:0]   out_iteration_count,
  output logic [met_pkg::POS_W-1:0]   out_column_out,
  output logic [met_pkg::POS_W-1:0]   out_row_out
);
  import met_pkg::*;

  localparam int M_W  = 31;          // multiplier operand width
  localparam int P_W  = 2 * M_W;     // product width
  localparam int SQ_W = P_W - FRAC_BITS;
  localparam logic [SQ_W:0] BOUND = (SQ_W+1)'(4) << FRAC_BITS;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_ADD  = 4'b0100,
    S_WB   = 4'b1000
  } state_t;

  state_t                   state_r, state_nxt;
  logic signed [Z_W-1:0]    zr_r, zr_nxt, zi_r, zi_nxt;
  logic signed [COORD_W-1:0] cr_r, ci_r;
  logic [POS_W-1:0]         col_r, row_r;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic signed [P_W-1:0]    prr_r, pii_r, pri_r;
  logic                     out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]         out_cnt_r;
  logic [POS_W-1:0]         out_col_r, out_row_r;
  logic                     zr_small, zi_small;
  logic signed [M_W-1:0]    zr_m, zi_m;
  logic [SQ_W-1:0]          rr, ii;
  logic [SQ_W:0]            mag;
  logic signed [P_W-FRAC_BITS:0] ri;
  logic                     load_item, do_mul, out_load, slot_free;

  assign zr_small  = (zr_r[Z_W-1:M_W-1] == '0) || (zr_r[Z_W-1:M_W-1] == '1);
  assign zi_small  = (zi_r[Z_W-1:M_W-1] == '0) || (zi_r[Z_W-1:M_W-1] == '1);
  assign zr_m      = zr_r[M_W-1:0];
  assign zi_m      = zi_r[M_W-1:0];
  // floor of the squares and of twice the cross product
  assign rr        = prr_r[P_W-1:FRAC_BITS];
  assign ii        = pii_r[P_W-1:FRAC_BITS];
  assign ri        = pri_r[P_W-1:FRAC_BITS-1];
  assign mag       = {1'b0, rr} + {1'b0, ii};
  assign slot_free = !out_valid_r || out_pop;
  assign out_empty = !out_valid_r;
  assign q_pop     = load_item;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    zr_nxt    = zr_r;
    zi_nxt    = zi_r;
    cnt_nxt   = cnt_r;
    load_item = 1'b0;
    do_mul    = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          load_item = 1'b1;
          zr_nxt    = '0;
          zi_nxt    = '0;
          cnt_nxt   = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        // a component at or beyond 4.0 has escaped already
        if (cnt_r != '0 && !(zr_small && zi_small)) begin
          state_nxt = S_WB;
        end else begin
          do_mul    = 1'b1;
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        if (cnt_r != '0 && mag >= BOUND) begin
          state_nxt = S_WB;
        end else if (cnt_r != '0 && cnt_r >= iteration_limit) begin
          state_nxt = S_WB;
        end else begin
          zr_nxt    = Z_W'($signed({1'b0, rr})) - Z_W'($signed({1'b0, ii}))
                      + Z_W'(cr_r);
          zi_nxt    = Z_W'(ri) + Z_W'(ci_r);
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_WB: begin
        if (slot_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_pop && out_valid_r) out_valid_nxt = 1'b0;
    if (out_load)               out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    zr_r  <= zr_nxt;
    zi_r  <= zi_nxt;
    cnt_r <= cnt_nxt;
    if (load_item) begin
      cr_r  <= q_item.cr;
      ci_r  <= q_item.ci;
      col_r <= q_item.column;
      row_r <= q_item.row;
    end
    if (do_mul) begin
      prr_r <= P_W'(zr_m) * P_W'(zr_m);
      pii_r <= P_W'(zi_m) * P_W'(zi_m);
      pri_r <= P_W'(zr_m) * P_W'(zi_m);
    end
    if (out_load) begin
      out_cnt_r <= cnt_r;
      out_col_r <= col_r;
      out_row_r <= row_r;
    end
  end

  assign out_iteration_count = out_cnt_r;
  assign out_column_out      = out_col_r;
  assign out_row_out         = out_row_r;

endmodule
